// ===== hdl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Item and result structs, action codes, control characters and the
// front-to-back command record.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_SETC  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] REG_FG = 2'd0;
  localparam logic [1:0] REG_BG = 2'd1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  shown_column;
    logic [4:0]  shown_row;
    logic [10:0] cursor_location;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_item_t;

  // Decoded command handed from the front part to the back part
  localparam logic [2:0] CMD_WRITE  = 3'd0;  // write char at cursor, advance
  localparam logic [2:0] CMD_LF     = 3'd1;
  localparam logic [2:0] CMD_BS     = 3'd2;
  localparam logic [2:0] CMD_CR     = 3'd3;
  localparam logic [2:0] CMD_TAB    = 3'd4;
  localparam logic [2:0] CMD_SETC   = 3'd5;
  localparam logic [2:0] CMD_CLEAR  = 3'd6;
  localparam logic [2:0] CMD_READ   = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] char_code;
    logic [6:0] column;
    logic [4:0] row;
  } cmd_t;

endpackage

// ===== hdl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front: item intake and classification
// Accepts input items, decodes action and control characters, and pushes a
// command into a two-entry queue toward the back part.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::in_item_t in_data,
  output logic              q_valid,
  output tcw_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);
  import tcw_pkg::*;

  cmd_t       q_mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.char_code = in_data.char_code;
    dec.column    = in_data.column;
    dec.row       = in_data.row;
    unique case (in_data.action)
      ACT_PUT: begin
        case (in_data.char_code)
          CH_LF:   dec.cmd = CMD_LF;
          CH_BS:   dec.cmd = CMD_BS;
          CH_CR:   dec.cmd = CMD_CR;
          CH_TAB:  dec.cmd = CMD_TAB;
          default: dec.cmd = CMD_WRITE;
        endcase
      end
      ACT_SETC:  dec.cmd = CMD_SETC;
      ACT_CLEAR: dec.cmd = CMD_CLEAR;
      default:   dec.cmd = CMD_READ;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (q_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== hdl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back: screen memory and cursor engine
// Executes one command at a time on the cell memory. Clear (also run at
// reset) sweeps one cell per cycle; scroll reads, then writes, each cell.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tcw_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic [3:0]         fg,
  input  logic [3:0]         bg,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_END = AW'(COLUMNS * (ROWS - 1));
  localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_SCRL_R = 3'd2;  // issue read of cell below
  localparam logic [2:0] S_SCRL_W = 3'd3;  // write it one row up
  localparam logic [2:0] S_BLANK  = 3'd4;  // blank bottom row
  localparam logic [2:0] S_READ   = 3'd5;  // wait for read data
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] ccol_r, ccol_nxt;
  logic [RW-1:0] crow_r, crow_nxt;
  logic          scr_r, scr_nxt;
  logic          rd_r, rd_nxt;
  logic          ov_r, ov_nxt;
  logic          clr_cmd_r, clr_cmd_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;
  logic          re;
  logic [15:0]   blank;
  logic [AW-1:0] cur_addr;
  logic [CW:0]   tab_col;
  logic [CW-1:0] sat_c;
  logic [RW-1:0] sat_r;

  assign blank    = {bg, fg, CH_SPACE};
  // row*COLUMNS, one small multiplier
  assign cur_addr = AW'(crow_r * COLUMNS) + AW'(ccol_r);
  assign tab_col  = ({1'b0, ccol_r} + (CW+1)'(4)) & ~(CW+1)'(3);
  assign sat_c    = (32'(q_cmd.column) >= COLUMNS) ? LAST_COL : CW'(q_cmd.column);
  assign sat_r    = (32'(q_cmd.row) >= ROWS) ? LAST_ROW : RW'(q_cmd.row);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_comb begin
    st_nxt      = st_r;
    ptr_nxt     = ptr_r;
    ccol_nxt    = ccol_r;
    crow_nxt    = crow_r;
    scr_nxt     = scr_r;
    rd_nxt      = rd_r;
    ov_nxt      = ov_r;
    clr_cmd_nxt = clr_cmd_r;
    we          = 1'b0;
    waddr       = cur_addr;
    wdata       = blank;
    re          = 1'b0;
    raddr       = ptr_r;
    q_pop       = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          scr_nxt = 1'b0;
          rd_nxt  = 1'b0;
          st_nxt  = S_OUT;
          case (q_cmd.cmd)
            CMD_WRITE: begin
              we    = 1'b1;
              wdata = {bg, fg, q_cmd.char_code};
              if (ccol_r == LAST_COL) begin
                ccol_nxt = '0;
                if (crow_r == LAST_ROW) begin
                  scr_nxt = 1'b1;
                  ptr_nxt = '0;
                  st_nxt  = S_SCRL_R;
                end else crow_nxt = crow_r + 1'b1;
              end else ccol_nxt = ccol_r + 1'b1;
            end
            CMD_LF, CMD_TAB: begin
              if (q_cmd.cmd == CMD_TAB && 32'(tab_col) < COLUMNS) begin
                ccol_nxt = CW'(tab_col);
              end else begin
                ccol_nxt = '0;
                if (crow_r == LAST_ROW) begin
                  scr_nxt = 1'b1;
                  ptr_nxt = '0;
                  st_nxt  = S_SCRL_R;
                end else crow_nxt = crow_r + 1'b1;
              end
            end
            CMD_BS: begin
              // blank the cell at the cursor after stepping back
              we = 1'b1;
              if (ccol_r != '0) begin
                ccol_nxt = ccol_r - 1'b1;
                waddr    = cur_addr - 1'b1;
              end else if (crow_r != '0) begin
                crow_nxt = crow_r - 1'b1;
                ccol_nxt = LAST_COL;
                waddr    = cur_addr - 1'b1;
              end
            end
            CMD_CR:   ccol_nxt = '0;
            CMD_SETC: begin
              ccol_nxt = sat_c;
              crow_nxt = sat_r;
            end
            CMD_CLEAR: begin
              ccol_nxt    = '0;
              crow_nxt    = '0;
              ptr_nxt     = '0;
              clr_cmd_nxt = 1'b1;
              st_nxt      = S_CLEAR;
            end
            default: begin
              re     = 1'b1;
              raddr  = AW'(sat_r * COLUMNS) + AW'(sat_c);
              rd_nxt = 1'b1;
              st_nxt = S_READ;
            end
          endcase
        end
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_r;
        // the reset sweep has no result to hand out
        if (ptr_r == LAST_CELL) begin
          clr_cmd_nxt = 1'b0;
          st_nxt      = clr_cmd_r ? S_OUT : S_IDLE;
        end else ptr_nxt = ptr_r + 1'b1;
      end
      S_SCRL_R: begin
        re     = 1'b1;
        raddr  = ptr_r + AW'(COLUMNS);
        st_nxt = S_SCRL_W;
      end
      S_SCRL_W: begin
        we    = 1'b1;
        waddr = ptr_r;
        wdata = rdata_r;
        ptr_nxt = ptr_r + 1'b1;
        st_nxt  = (ptr_r + 1'b1 == SCROLL_END) ? S_BLANK : S_SCRL_R;
      end
      S_BLANK: begin
        we    = 1'b1;
        waddr = ptr_r;
        if (ptr_r == LAST_CELL) st_nxt = S_OUT;
        else ptr_nxt = ptr_r + 1'b1;
      end
      S_READ: st_nxt = S_OUT;
      S_OUT: begin
        ov_nxt = 1'b1;
        if (ov_r && !out_stall) begin
          ov_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLEAR;
      ptr_r     <= '0;
      ccol_r    <= '0;
      crow_r    <= '0;
      scr_r     <= 1'b0;
      rd_r      <= 1'b0;
      ov_r      <= 1'b0;
      clr_cmd_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      ptr_r     <= ptr_nxt;
      ccol_r    <= ccol_nxt;
      crow_r    <= crow_nxt;
      scr_r     <= scr_nxt;
      rd_r      <= rd_nxt;
      ov_r      <= ov_nxt;
      clr_cmd_r <= clr_cmd_nxt;
    end
  end

  assign out_valid = ov_r;
  always_comb begin
    out_data.shown_column    = 7'(ccol_r);
    out_data.shown_row       = 5'(crow_r);
    out_data.cursor_location = 11'(32'(crow_r) * COLUMNS + 32'(ccol_r));
    out_data.cell_value      = rd_r ? rdata_r : 16'h0000;
    out_data.scrolled        = scr_r;
  end

endmodule

// ===== hdl/text_console_writer_top.sv =====
// Path: an item passes the front queue, the back part's command state and the
// output valid register; a cell read also passes the read-wait state. A scroll
// copies each cell one row up, a read then a write, then blanks the bottom row;
// a clear sweeps every cell. The back part runs one item at a time; the front
// queue holds up to two more. Reset: synchronous; a clear pass blanks the screen
// with 0x0F20; up to two items are taken into the queue meanwhile and wait.
// ----------------------------------------------------------------------------
// text_console_writer_top: text console with cursor and scroll
// Front part decodes items into a short queue; back part runs the screen.
// ----------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcw_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tcw_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);
  import tcw_pkg::*;

  logic [3:0] fg_r, bg_r;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 4'hF;
      bg_r <= 4'h0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FG) fg_r <= cfg_data;
      if (cfg_index == REG_BG) bg_r <= cfg_data;
    end
  end

  tcw_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_cmd, .q_pop
  );

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .fg(fg_r), .bg(bg_r),
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== hdl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches handshakes and result fields.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tcw_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tcw_pkg::out_item_t out_data
);
  import tcw_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.shown_row) < ROWS)
    else $error("row out of range");

  a_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cursor_location ==
      11'(32'(out_data.shown_row) * COLUMNS + 32'(out_data.shown_column)))
    else $error("cursor location mismatch");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result during reset");

endmodule

bind text_console_writer_top tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data
);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for text_console_writer_top
// Drives put, set-cursor, clear and read items through the valid/stall
// channel, predicts the cursor, scroll flag and cell contents with a screen
// model of its own, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS  = 80;
  localparam int LINES = 25;
  localparam int CELLS = COLS * LINES;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  text_console_writer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // screen model
  logic [15:0] scr [CELLS];
  int unsigned cur_col, cur_row;
  logic [3:0] fg_col, bg_col;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int n_results = 0;
  int n_scrolls = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic logic [15:0] blank();
    return {bg_col, fg_col, CH_SPACE};
  endfunction

  function automatic void wipe_screen();
    for (int i = 0; i < CELLS; i++) scr[i] = blank();
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic bit advance_row();
    cur_row++;
    if (cur_row >= LINES) begin
      for (int i = 0; i < CELLS - COLS; i++) scr[i] = scr[i + COLS];
      for (int x = 0; x < COLS; x++) scr[CELLS - COLS + x] = blank();
      cur_row = LINES - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_item_t console_step(in_item_t it);
    out_item_t r;
    bit sc;
    int unsigned c, rw;
    logic [15:0] cell_val;
    sc = 1'b0;
    cell_val = '0;
    c  = (it.column >= COLS) ? COLS - 1 : it.column;
    rw = (it.row >= LINES) ? LINES - 1 : it.row;
    case (it.action)
      ACT_PUT: begin
        if (it.char_code == CH_LF) begin
          cur_col = 0;
          sc = advance_row();
        end else if (it.char_code == CH_BS) begin
          if (cur_col > 0) cur_col--;
          else if (cur_row > 0) begin
            cur_row--;
            cur_col = COLS - 1;
          end
          scr[cur_row * COLS + cur_col] = blank();
        end else if (it.char_code == CH_CR) begin
          cur_col = 0;
        end else if (it.char_code == CH_TAB) begin
          cur_col = (cur_col + 4) & ~32'd3;
          if (cur_col >= COLS) begin
            cur_col = 0;
            sc = advance_row();
          end
        end else begin
          scr[cur_row * COLS + cur_col] = {bg_col, fg_col, it.char_code};
          cur_col++;
          if (cur_col >= COLS) begin
            cur_col = 0;
            sc = advance_row();
          end
        end
      end
      ACT_SETC: begin
        cur_col = c;
        cur_row = rw;
      end
      ACT_CLEAR: wipe_screen();
      default: cell_val = scr[rw * COLS + c];
    endcase
    r.shown_column    = cur_col[6:0];
    r.shown_row       = cur_row[4:0];
    r.cursor_location = 11'(cur_row * COLS + cur_col);
    r.cell_value      = cell_val;
    r.scrolled        = sc;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(console_step(in_data));
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid && pending_items.size() > 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_data);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (e.scrolled) n_scrolls++;
        if (e.shown_column !== out_data.shown_column)
          $display("%0t: shown_column exp %0d got %0d", $time, e.shown_column,
                   out_data.shown_column);
        if (e.shown_row !== out_data.shown_row)
          $display("%0t: shown_row exp %0d got %0d", $time, e.shown_row,
                   out_data.shown_row);
        if (e.cursor_location !== out_data.cursor_location)
          $display("%0t: cursor_location exp %0d got %0d", $time,
                   e.cursor_location, out_data.cursor_location);
        if (e.cell_value !== out_data.cell_value)
          $display("%0t: cell_value exp %h got %h", $time, e.cell_value,
                   out_data.cell_value);
        if (e.scrolled !== out_data.scrolled)
          $display("%0t: scrolled exp %0d got %0d", $time, e.scrolled,
                   out_data.scrolled);
        if (e !== out_data) errors++;
      end
    end
  end

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_FG) fg_col = val;
    else bg_col = val;
  endtask

  function automatic in_item_t mk(logic [1:0] a, logic [7:0] ch, logic [6:0] c,
                                  logic [4:0] r);
    in_item_t it;
    it.action = a;
    it.char_code = ch;
    it.column = c;
    it.row = r;
    return it;
  endfunction

  function automatic in_item_t rand_item();
    int p;
    logic [7:0] ch;
    p = $urandom_range(99);
    ch = $urandom_range(255);
    if (p < 8) ch = CH_LF;
    else if (p < 12) ch = CH_BS;
    else if (p < 14) ch = CH_CR;
    else if (p < 18) ch = CH_TAB;
    if (p < 70) return mk(ACT_PUT, ch, 7'($urandom), 5'($urandom));
    if (p < 85) return mk(ACT_SETC, ch, 7'($urandom), 5'($urandom));
    if (p < 86) return mk(ACT_CLEAR, ch, 7'($urandom), 5'($urandom));
    return mk(ACT_READ, ch, 7'($urandom), 5'($urandom));
  endfunction

  initial begin
    fg_col = 4'hF;
    bg_col = 4'h0;
    wipe_screen();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_FG, 4'hF);
    write_reg(REG_BG, 4'h0);

    // directed: reads of reset screen, controls at edges, saturation
    pending_items.push_back(mk(ACT_READ, 8'h00, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, CH_BS, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, 8'hFF, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, 8'h00, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_READ, 8'h00, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, CH_TAB, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, CH_CR, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_SETC, 8'h00, 7'd127, 5'd31));
    pending_items.push_back(mk(ACT_PUT, 8'h41, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_PUT, CH_BS, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_READ, 8'h00, 7'd127, 5'd31));
    pending_items.push_back(mk(ACT_SETC, 8'h00, 7'd0, 5'd1));
    pending_items.push_back(mk(ACT_PUT, CH_BS, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_SETC, 8'h00, 7'd77, 5'd24));
    pending_items.push_back(mk(ACT_PUT, CH_TAB, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_SETC, 8'h00, 7'd10, 5'd24));
    pending_items.push_back(mk(ACT_PUT, CH_LF, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_READ, 8'h00, 7'd0, 5'd23));
    pending_items.push_back(mk(ACT_SETC, 8'h00, 7'd79, 5'd0));
    pending_items.push_back(mk(ACT_PUT, 8'h7E, 7'd0, 5'd0));
    pending_items.push_back(mk(ACT_CLEAR, 8'hFF, 7'd127, 5'd31));
    pending_items.push_back(mk(ACT_READ, 8'hFF, 7'd55, 5'd12));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 56; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 56; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      if (ph == 4) begin
        write_reg(REG_FG, 4'h0);
        write_reg(REG_BG, 4'hF);
      end else begin
        write_reg(REG_FG, 4'($urandom));
        write_reg(REG_BG, 4'($urandom));
      end
      for (int i = 0; i < 100; i++) pending_items.push_back(rand_item());
      drain();
    end

    $display("covered %0d results, %0d of them scrolls, six random phases",
             n_results, n_scrolls);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
